FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// a stalled transaction keeps its valid and its payload
`define ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(sig))) \
		else $error("%m: stalled transaction changed");

`endif

FILE: src/sdoup_pkg.sv
// ----------------------------------------------------------------------------
// sdoup_pkg
// types and constants of the sdo segmented upload client
// ----------------------------------------------------------------------------
package sdoup_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 2;
	localparam int unsigned ADDR_W = 3;

	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
	localparam logic [10:0] BOOT_ID_RESET = 11'h7FF;

	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_BOOT_ID = 1'b1;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_FRAME   = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_INIT_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_BAD_REPLY    = 3'd2;
	localparam logic [2:0] ST_ABORT        = 3'd3;
	localparam logic [2:0] ST_SEG_TIMEOUT  = 3'd4;
	localparam logic [2:0] ST_TOGGLE       = 3'd5;
	localparam logic [2:0] ST_BUF_FULL     = 3'd6;

	localparam logic [3:0] REQ_ID_HI = 4'hC;
	localparam logic [3:0] RSP_ID_HI = 4'hB;

	localparam logic [7:0] CMD_INIT_UPLOAD = 8'h40;
	localparam logic [7:0] CMD_SEG_REQ     = 8'h60;
	localparam logic [7:0] CMD_ABORT       = 8'h80;
	localparam logic [7:0] CCS_MASK        = 8'hE0;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_INIT,
		PH_SEG
	} phase_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [6:0]  node_id;
		logic [15:0] object_index;
		logic [10:0] frame_id;
		logic [63:0] frame_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] tx_id;
		logic [63:0] tx_payload;
		logic [7:0]  data_byte;
		logic [15:0] byte_position;
		logic [2:0]  status;
		logic        complete;
		logic [7:0]  abort_command;
		logic [15:0] byte_count;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  nbytes;
		logic [55:0] data;
		logic [15:0] base;
		logic [1:0]  tail_kind;
		logic [10:0] tx_id;
		logic [63:0] tx_payload;
		logic [2:0]  status;
		logic        complete;
		logic [7:0]  abort_command;
		logic [15:0] byte_count;
	} job_t;

endpackage

FILE: src/sdoup_front.sv
// ----------------------------------------------------------------------------
// sdoup_front
// accepts items, tracks the transfer state and builds at most one job per item
// ----------------------------------------------------------------------------
module sdoup_front import sdoup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	input  logic [15:0] max_len,
	input  logic [10:0] bootloader_id,
	input  logic        queue_full,
	output logic        push,
	output job_t        job
);

	phase_t      phase_q, phase_d;
	logic [6:0]  target_q, target_d;
	logic        toggle_q, toggle_d;
	logic [15:0] count_q, count_d;

	logic        accept;
	logic [7:0]  cmd;
	logic        id_match;
	logic [15:0] room;
	logic [2:0]  n_exp, n_exp_clip, n_seg, n_seg_clip;
	logic [15:0] count_new;

	logic        do_start, do_fin, do_req;
	logic [2:0]  fin_status;
	logic        fin_complete;
	logic [7:0]  fin_abort;
	logic [15:0] fin_count;
	logic [15:0] req_count;
	logic        req_toggle;

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;
	assign cmd        = item.frame_data[7:0];
	assign id_match   = (item.frame_id == {RSP_ID_HI, target_q}) ||
		(item.frame_id == bootloader_id);
	assign room       = (count_q >= max_len) ? 16'd0 : max_len - count_q;

	assign n_exp      = cmd[0] ? 3'd4 - {1'b0, cmd[3:2]} : 3'd4;
	assign n_exp_clip = ({13'd0, n_exp} > max_len) ? max_len[2:0] : n_exp;
	assign n_seg      = 3'd7 - cmd[3:1];
	assign n_seg_clip = ({13'd0, n_seg} > room) ? room[2:0] : n_seg;
	assign count_new  = count_q + {13'd0, n_seg_clip};

	always_comb begin
		phase_d      = phase_q;
		target_d     = target_q;
		toggle_d     = toggle_q;
		count_d      = count_q;
		do_start     = 1'b0;
		do_fin       = 1'b0;
		do_req       = 1'b0;
		fin_status   = ST_OK;
		fin_complete = 1'b0;
		fin_abort    = 8'd0;
		fin_count    = count_q;
		req_count    = count_q;
		req_toggle   = toggle_q;
		job          = '0;

		case (item.action)
			ACT_START: begin
				do_start       = 1'b1;
				target_d       = item.node_id;
				toggle_d       = 1'b0;
				count_d        = 16'd0;
				phase_d        = PH_INIT;
				job.tail_kind  = KIND_TX;
				job.tx_id      = {REQ_ID_HI, item.node_id};
				job.tx_payload = {40'd0, item.object_index, CMD_INIT_UPLOAD};
			end
			ACT_TIMEOUT: begin
				if (phase_q == PH_INIT) begin
					do_fin     = 1'b1;
					fin_status = ST_INIT_TIMEOUT;
				end else if (phase_q == PH_SEG) begin
					do_fin     = 1'b1;
					fin_status = ST_SEG_TIMEOUT;
				end
			end
			ACT_FRAME: begin
				if (phase_q == PH_INIT && id_match) begin
					if (cmd == CMD_ABORT) begin
						do_fin     = 1'b1;
						fin_status = ST_ABORT;
						fin_abort  = cmd;
					end else if ((cmd & CCS_MASK) != CMD_INIT_UPLOAD) begin
						do_fin     = 1'b1;
						fin_status = ST_BAD_REPLY;
						fin_abort  = cmd;
					end else if (cmd[1]) begin
						job.nbytes   = n_exp_clip;
						job.data     = {24'd0, item.frame_data[63:32]};
						job.base     = 16'd0;
						count_d      = {13'd0, n_exp_clip};
						do_fin       = 1'b1;
						fin_complete = 1'b1;
						fin_count    = {13'd0, n_exp_clip};
					end else begin
						toggle_d   = 1'b0;
						count_d    = 16'd0;
						do_req     = 1'b1;
						req_count  = 16'd0;
						req_toggle = 1'b0;
					end
				end else if (phase_q == PH_SEG && id_match) begin
					if (cmd[7]) begin
						do_fin     = 1'b1;
						fin_status = ST_ABORT;
						fin_abort  = cmd;
					end else if (cmd[4] != toggle_q) begin
						do_fin     = 1'b1;
						fin_status = ST_TOGGLE;
						fin_abort  = cmd;
					end else begin
						job.nbytes = n_seg_clip;
						job.data   = item.frame_data[63:8];
						job.base   = count_q;
						count_d    = count_new;
						if (cmd[0]) begin
							do_fin       = 1'b1;
							fin_complete = 1'b1;
							fin_count    = count_new;
						end else begin
							toggle_d   = !toggle_q;
							do_req     = 1'b1;
							req_count  = count_new;
							req_toggle = !toggle_q;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// segment request, or buffer full once the capacity is used up
		if (do_req) begin
			if (req_count >= max_len) begin
				do_fin     = 1'b1;
				fin_status = ST_BUF_FULL;
				fin_count  = req_count;
			end else begin
				job.tail_kind  = KIND_TX;
				job.tx_id      = {REQ_ID_HI, target_q};
				job.tx_payload = {56'd0, CMD_SEG_REQ | {3'd0, req_toggle, 4'd0}};
				phase_d        = PH_SEG;
			end
		end

		if (do_fin) begin
			job.tail_kind     = KIND_DONE;
			job.status        = fin_status;
			job.complete      = fin_complete;
			job.abort_command = fin_abort;
			job.byte_count    = fin_count;
			phase_d           = PH_IDLE;
		end

		push = accept && (do_start || do_fin || do_req);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			target_q <= 7'd0;
			toggle_q <= 1'b0;
			count_q  <= 16'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			target_q <= target_d;
			toggle_q <= toggle_d;
			count_q  <= count_d;
		end
	end

endmodule

FILE: src/sdoup_queue.sv
// ----------------------------------------------------------------------------
// sdoup_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module sdoup_queue import sdoup_pkg::*; #(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t head,
	output logic not_empty,
	output logic full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == CNT_W'(DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/sdoup_back.sv
// ----------------------------------------------------------------------------
// sdoup_back
// expands the head job into result transactions, one per cycle while not stalled by result_ready
// ----------------------------------------------------------------------------
module sdoup_back import sdoup_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      head_valid,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       load;
	logic       step;
	logic       is_tail;
	out_item_t  next_item;

	assign load    = !out_valid_q || result_ready;
	assign step    = load && head_valid;
	assign is_tail = idx_q == head.nbytes;
	assign pop     = step && is_tail;

	always_comb begin
		next_item = '0;
		if (is_tail) begin
			next_item.kind          = head.tail_kind;
			next_item.tx_id         = head.tx_id;
			next_item.tx_payload    = head.tx_payload;
			next_item.status        = head.status;
			next_item.complete      = head.complete;
			next_item.abort_command = head.abort_command;
			next_item.byte_count    = head.byte_count;
			next_item.last          = 1'b1;
		end else begin
			next_item.kind          = KIND_DATA;
			next_item.data_byte     = head.data[{idx_q, 3'b000} +: 8];
			next_item.byte_position = head.base + {13'd0, idx_q};
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= next_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (step) begin
				idx_q <= is_tail ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: src/sdo_segmented_upload_client.sv
// ----------------------------------------------------------------------------
// sdo_segmented_upload_client
// canopen sdo upload client with expedited and segmented transfers
// ----------------------------------------------------------------------------
// The front end takes one item per cycle whenever the job queue (QUEUE_DEPTH
// entries) has room; each item yields zero to eight result transactions, which
// the back end sends one per cycle while result_ready is high, from its output
// register. An item that delivers n data bytes yields n data transactions and
// one tail transaction, and the back end sequencer sets the sustained rate.
// Registers: max_len at byte address 0, bootloader_id at byte address 4.
// ----------------------------------------------------------------------------
module sdo_segmented_upload_client import sdoup_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  in_item_t          item,
	output logic              result_valid,
	input  logic              result_ready,
	output out_item_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [15:0] max_len_q;
	logic [10:0] boot_id_q;
	logic        cfg_wr;

	logic        push, pop, queue_full, queue_not_empty;
	job_t        new_job, head_job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			boot_id_q <= BOOT_ID_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_LEN: max_len_q <= pwdata[15:0];
				REG_BOOT_ID: boot_id_q <= pwdata[10:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_LEN: prdata = {16'd0, max_len_q};
			REG_BOOT_ID: prdata = {21'd0, boot_id_q};
			default:     prdata = 32'd0;
		endcase
	end

	sdoup_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.max_len       (max_len_q),
		.bootloader_id (boot_id_q),
		.queue_full    (queue_full),
		.push          (push),
		.job           (new_job)
	);

	sdoup_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (new_job),
		.pop       (pop),
		.head      (head_job),
		.not_empty (queue_not_empty),
		.full      (queue_full)
	);

	sdoup_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_job),
		.head_valid   (queue_not_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: src/sdoup_checker.sv
// ----------------------------------------------------------------------------
// sdoup_checker
// port level checks of the sdo segmented upload client
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdoup_checker import sdoup_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	logic result_xfer;
	logic data_xfer;

	assign result_xfer = result_valid && result_ready;
	assign data_xfer   = result_xfer && (result.kind == KIND_DATA);

	`ASSERT_HOLD(a_result_hold, clk, arst_n, result_valid, result_ready, result)

	// back to back data bytes of one job sit at consecutive positions
	`ASSERT_AT(a_pos_step, clk, arst_n,
		(data_xfer && $past(data_xfer)) |->
		(result.byte_position == $past(result.byte_position) + 16'd1))

	`ASSERT_AT(a_done_complete, clk, arst_n,
		(result_valid && result.kind == KIND_DONE) |->
		(result.complete == (result.status == ST_OK)))

	`ASSERT_AT(a_data_not_last, clk, arst_n,
		(result_valid && result.kind == KIND_DATA) |-> !result.last)

endmodule

bind sdo_segmented_upload_client sdoup_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
